FILE: rtl/core/ndrf_pkg.sv
// ----------------------------------------------------------------------------
// ndrf_pkg
// Shared types and constants of the near-duplicate row filter.
// ----------------------------------------------------------------------------
package ndrf_pkg;

  localparam int VALUE_W   = 32;
  localparam int TOL_W     = 31;
  localparam int LEN_CFG_W = 5;
  localparam int INDEX_W   = 6;
  localparam int COUNT_W   = 7;
  localparam int CFG_W     = TOL_W;

  localparam logic [TOL_W-1:0]     TOL_RESET = TOL_W'(655);   // about 0.01 in Q16.16
  localparam logic [LEN_CFG_W-1:0] LEN_RESET = LEN_CFG_W'(16);

  typedef enum logic [0:0] {
    REG_MATCH_TOLERANCE = 1'b0,
    REG_ROW_LENGTH      = 1'b1
  } cfg_reg_t;

  // Element broadcast to the compare cells in the cycle after its transfer
  typedef struct packed {
    logic               valid;
    logic               start;
    logic               last;
    logic [VALUE_W-1:0] value;
  } cmp_cmd_t;

endpackage

FILE: rtl/core/ndrf_ram.sv
// ----------------------------------------------------------------------------
// ndrf_ram
// Generic single-port RAM, one access per cycle (read, plus write when we), registered read.
// ----------------------------------------------------------------------------
module ndrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/core/ndrf_cell.sv
// ----------------------------------------------------------------------------
// ndrf_cell
// One table row: its stored elements and its still-matching flag.
// ----------------------------------------------------------------------------
module ndrf_cell
  import ndrf_pkg::*;
#(
  parameter int MAX_COLS = 16,
  parameter int CW       = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [CW-1:0]      addr,
  input  logic [VALUE_W-1:0] wdata,
  input  cmp_cmd_t           cmd,
  input  logic [TOL_W-1:0]   tol,
  output logic               hit
);

  logic [VALUE_W-1:0] stored;
  logic               match;
  logic               base;
  logic               ok;
  logic signed [VALUE_W:0] diff;
  logic signed [VALUE_W:0] lim;

  ndrf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_COLS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (stored)
  );

  // exact 33-bit difference, checked against +/- tolerance
  always_comb begin
    diff = $signed({stored[VALUE_W-1], stored}) - $signed({cmd.value[VALUE_W-1], cmd.value});
    lim  = $signed({2'b00, tol});
    ok   = (diff <= lim) && (diff >= -lim);
    base = cmd.start | match;
    hit  = base & ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b1;
    end else if (cmd.valid) begin
      match <= cmd.last ? 1'b1 : hit;
    end
  end

endmodule

FILE: rtl/core/ndrf_find.sv
// ----------------------------------------------------------------------------
// ndrf_find
// Registered priority tree: lowest set bit of the hit vector.
// ----------------------------------------------------------------------------
module ndrf_find #(
  parameter int N = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [N-1:0]          hits,
  input  logic                  ack,
  output logic                  done,
  output logic                  found,
  output logic [$clog2(N)-1:0]  index
);

  localparam int L  = $clog2(N);
  localparam int P  = 1 << L;
  localparam int KW = $clog2(L + 1);

  logic [P-1:0]  leaf;
  logic          inner_f [1:P-1];
  logic [L-1:0]  inner_i [1:P-1];
  logic          busy;
  logic [KW-1:0] cnt;

  // leaves hold until the next load, so every level settles and stays put
  always_ff @(posedge clk) begin
    if (load) begin
      leaf <= P'(hits);
    end
  end

  for (genvar i = 1; i < P; i++) begin : g_node
    if (2 * i >= P) begin : g_bottom
      always_ff @(posedge clk) begin
        inner_f[i] <= leaf[2*i-P] | leaf[2*i+1-P];
        inner_i[i] <= leaf[2*i-P] ? L'(2*i-P) : L'(2*i+1-P);
      end
    end else begin : g_upper
      always_ff @(posedge clk) begin
        inner_f[i] <= inner_f[2*i] | inner_f[2*i+1];
        inner_i[i] <= inner_f[2*i] ? inner_i[2*i] : inner_i[2*i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= KW'(L);
    end else begin
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
      if (ack) begin
        busy <= 1'b0;
      end
    end
  end

  assign done  = busy && (cnt == '0);
  assign found = inner_f[1];
  assign index = inner_i[1];

endmodule

FILE: rtl/core/near_duplicate_row_filter.sv
// ----------------------------------------------------------------------------
// near_duplicate_row_filter
// Streams matrix rows element by element and reports, per row, whether it is
// new or repeats a stored row within the element tolerance.
// ----------------------------------------------------------------------------
// Elements inside a row: one transfer per cycle, compared in all row cells at once.
// Last element of a row: its verdict passes the compare broadcast register, the tree
//   leaves and the registered tree levels into the result register; input is held off
//   until the verdict is registered, and a result not yet taken holds off the verdict.
// Reset (synchronous): table empty, column 0, tolerance 655, row length 16.
//   Row storage is not cleared; entries are only used once written.
module near_duplicate_row_filter
  import ndrf_pkg::*;
#(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [0:0]           cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [VALUE_W-1:0] value,
  input  logic                 starts_matrix,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 is_new,
  output logic [INDEX_W-1:0]   match_index,
  output logic [COUNT_W-1:0]   unique_count,
  output logic                 table_full
);

  localparam int IW   = $clog2(MAX_ROWS);
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int LENW = ($clog2(MAX_COLS + 1) > LEN_CFG_W) ? $clog2(MAX_COLS + 1) : LEN_CFG_W;

  logic [TOL_W-1:0]     match_tolerance;
  logic [LEN_CFG_W-1:0] row_length;

  logic [RW-1:0]   distinct_rows;
  logic [CW-1:0]   colpos;
  logic            pending;
  cmp_cmd_t        cmd;

  logic            accept;
  logic [CW-1:0]   col_cur;
  logic [LENW-1:0] len;
  logic [LENW-1:0] col_inc;
  logic            last;
  logic [RW-1:0]   wr_row;
  logic            wr_ok;
  logic            room;

  logic [MAX_ROWS-1:0] hit;
  logic [MAX_ROWS-1:0] hit_valid;

  logic            find_done;
  logic            find_found;
  logic [IW-1:0]   find_index;
  logic            commit;
  logic [IW+INDEX_W-1:0] idx_ext;
  logic [RW+COUNT_W-1:0] cnt_ext;
  logic [RW-1:0]   distinct_inc;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= TOL_RESET;
      row_length      <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MATCH_TOLERANCE: match_tolerance <= cfg_data;
        REG_ROW_LENGTH:      row_length      <= cfg_data[LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective row length: zero reads as one, saturated at MAX_COLS
  always_comb begin
    len = LENW'(row_length);
    if (len == '0) begin
      len = LENW'(1);
    end else if (len > LENW'(MAX_COLS)) begin
      len = LENW'(MAX_COLS);
    end
  end

  assign in_ready = !pending;
  assign accept   = in_valid && in_ready;
  assign col_cur  = starts_matrix ? '0 : colpos;
  assign col_inc  = LENW'(col_cur) + LENW'(1);
  assign last     = col_inc >= len;
  assign wr_row   = starts_matrix ? '0 : distinct_rows;
  assign wr_ok    = wr_row < RW'(MAX_ROWS);
  // table space at verdict time, independent of the waiting input
  assign room     = distinct_rows < RW'(MAX_ROWS);

  // element position and the compare broadcast
  always_ff @(posedge clk) begin
    if (rst) begin
      colpos    <= '0;
      cmd.valid <= 1'b0;
    end else begin
      cmd.valid <= accept;
      if (accept) begin
        colpos    <= last ? '0 : CW'(col_inc);
        cmd.start <= starts_matrix;
        cmd.last  <= last;
        cmd.value <= value;
      end
    end
  end

  // the incoming row is written straight into the next free cell
  for (genvar r = 0; r < MAX_ROWS; r++) begin : g_cell
    ndrf_cell #(
      .MAX_COLS (MAX_COLS),
      .CW       (CW)
    ) u_cell (
      .clk   (clk),
      .rst   (rst),
      .we    (accept && wr_ok && (wr_row == RW'(r))),
      .addr  (col_cur),
      .wdata (value),
      .cmd   (cmd),
      .tol   (match_tolerance),
      .hit   (hit[r])
    );
    assign hit_valid[r] = hit[r] && (distinct_rows > RW'(r));
  end

  ndrf_find #(
    .N (MAX_ROWS)
  ) u_find (
    .clk   (clk),
    .rst   (rst),
    .load  (cmd.valid && cmd.last),
    .hits  (hit_valid),
    .ack   (commit),
    .done  (find_done),
    .found (find_found),
    .index (find_index)
  );

  assign commit       = find_done && (!out_valid || out_ready);
  assign distinct_inc = distinct_rows + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      distinct_rows <= '0;
    end else begin
      if (accept && last) begin
        pending <= 1'b1;
      end else if (commit) begin
        pending <= 1'b0;
      end
      if (accept && starts_matrix) begin
        distinct_rows <= '0;
      end else if (commit && !find_found && room) begin
        distinct_rows <= distinct_inc;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    idx_ext = '0;
    cnt_ext = {{COUNT_W{1'b0}}, distinct_rows};
    if (find_found) begin
      idx_ext = {{INDEX_W{1'b0}}, find_index};
    end else if (room) begin
      idx_ext = (IW + INDEX_W)'(distinct_rows);
      cnt_ext = {{COUNT_W{1'b0}}, distinct_inc};
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      is_new       <= !find_found;
      table_full   <= !find_found && !room;
      match_index  <= idx_ext[INDEX_W-1:0];
      unique_count <= cnt_ext[COUNT_W-1:0];
    end
  end

endmodule
